@@ rtl/dti_pkg.sv @@
// Shared types and constants for the decision tree inference block.
package dti_pkg;

    localparam int NODES          = 256;
    localparam int FEATURES       = 64;
    localparam int MAX_CATEGORIES = 32;

    localparam int NODE_AW  = $clog2(NODES);
    localparam int FEAT_AW  = $clog2(FEATURES);
    localparam int INDEX_W  = 8;
    localparam int VALUE_W  = 32;
    localparam int MASK_W   = 32;
    localparam int CAT_W    = 6;
    localparam int LIMIT_W  = 9;

    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 48;

    localparam logic [LIMIT_W-1:0] STEP_LIMIT_RESET = LIMIT_W'(256);
    localparam logic [CAT_W-1:0]   CAT_NUMERIC      = CAT_W'(1);

    typedef enum logic [1:0] {
        FUNC_WR_NODE  = 2'd0,
        FUNC_WR_FEAT  = 2'd1,
        FUNC_WR_CAT   = 2'd2,
        FUNC_PREDICT  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_NODE,
        ST_FEAT
    } state_t;

    typedef struct packed {
        logic                      is_leaf;
        logic [FEAT_AW-1:0]        split_var;
        logic [NODE_AW-1:0]        left_child;
        logic [NODE_AW-1:0]        right_child;
        logic signed [VALUE_W-1:0] value;
        logic [MASK_W-1:0]         category_mask;
    } node_entry_t;

endpackage

@@ rtl/decision_tree_inference.sv @@
// Decision tree inference engine: node and feature memories with a tree-walk sequencer.
//
// Usage: items arrive on the s_ channel; s_tuser carries func (write node, write feature
// value, write category count, predict) and s_tdata the remaining fields. Write items are
// taken while the block is idle and produce no result. A predict item walks the tree from node 0 and
// returns one result on the m_ channel: the leaf value, the leaf index and a fault flag.
// A predict item first reads node 0; for each non-leaf node the block then reads the
// feature memory and fetches the chosen child from the node memory; both are registered
// reads. At a leaf, or when the step limit runs out, the result register is loaded and
// m_tvalid rises in the same cycle. The block takes one item at a time; s_tready is low
// during a walk. The result register decouples the sides: write items are accepted while
// a result waits. If a walk finishes while the previous result is still not taken, the
// walk holds its final node until m_tready frees the register. The user writes step_limit
// through cfg_we/cfg_wdata only while the block is idle; the block itself does not
// enforce this. Zero acts as 1. Reset (aresetn low, synchronous) sets step_limit to 256,
// marks every feature numeric and drops any pending result. Node and feature values stay
// unwritten until loaded.
module decision_tree_inference (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration: step_limit
    input  logic                              cfg_we,
    input  logic [dti_pkg::LIMIT_W-1:0]       cfg_wdata,
    // input items
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // index[7:0], is_leaf[8], split_var[14:9], left_child[22:15], right_child[30:23],
    // value[62:31], category_mask[94:63], category_count[100:95], zero pad[103:101]
    input  logic [dti_pkg::S_TDATA_W-1:0]     s_tdata,
    // func[1:0]
    input  logic [1:0]                        s_tuser,
    // results
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // prediction[31:0], leaf_index[39:32], fault[40], zero pad[47:41]
    output logic [dti_pkg::M_TDATA_W-1:0]     m_tdata
);
    import dti_pkg::*;

    // Unpack input fields
    func_t                      in_func;
    logic [INDEX_W-1:0]         in_index;
    node_entry_t                in_node;
    logic [CAT_W-1:0]           in_cat;
    logic                       s_accept;

    assign in_func                = func_t'(s_tuser);
    assign in_index               = s_tdata[7:0];
    assign in_node.is_leaf        = s_tdata[8];
    assign in_node.split_var      = s_tdata[14:9];
    assign in_node.left_child     = s_tdata[22:15];
    assign in_node.right_child    = s_tdata[30:23];
    assign in_node.value          = s_tdata[62:31];
    assign in_node.category_mask  = s_tdata[94:63];
    assign in_cat                 = s_tdata[100:95];
    assign s_accept               = s_tvalid && s_tready;

    // Configuration register
    logic [LIMIT_W-1:0] step_limit_reg;
    logic [LIMIT_W-1:0] limit_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_limit_reg <= STEP_LIMIT_RESET;
        end else if (cfg_we) begin
            step_limit_reg <= cfg_wdata;
        end
    end

    assign limit_eff = (step_limit_reg == '0) ? LIMIT_W'(1) : step_limit_reg;

    // Walk control registers
    state_t               state_reg, state_next;
    logic [NODE_AW-1:0]   node_reg, node_next;
    logic [LIMIT_W-1:0]   visits_reg, visits_next;

    // Result register
    logic                      m_tvalid_reg;
    logic signed [VALUE_W-1:0] pred_reg;
    logic [NODE_AW-1:0]        leaf_idx_reg;
    logic                      fault_reg;

    // Memory control
    logic                 node_we, node_rd_en;
    logic [NODE_AW-1:0]   node_rd_addr;
    logic                 feat_we_val, feat_we_cat, feat_rd_en;
    logic [FEAT_AW-1:0]   feat_wr_addr;
    logic [FEAT_AW-1:0]   feat_rd_addr;
    logic                 feat_idx_ok;
    logic                 result_load;

    // Node memory: links, threshold/leaf value and category mask in one word
    node_entry_t node_mem [NODES];
    node_entry_t node_q;

    always_ff @(posedge aclk) begin
        if (node_we) begin
            node_mem[in_index[NODE_AW-1:0]] <= in_node;
        end
        if (node_rd_en) begin
            node_q <= node_mem[node_rd_addr];
        end
    end

    // Feature memory: value in the low field, category count in the high field
    logic [CAT_W+VALUE_W-1:0] feat_mem [FEATURES];
    logic [CAT_W+VALUE_W-1:0] feat_q;
    logic [FEATURES-1:0]      cat_vld_reg;
    logic                     cat_vld_q;

    always_ff @(posedge aclk) begin
        if (feat_we_val) begin
            feat_mem[feat_wr_addr][VALUE_W-1:0] <= in_node.value;
        end
        if (feat_we_cat) begin
            feat_mem[feat_wr_addr][CAT_W+VALUE_W-1:VALUE_W] <= in_cat;
        end
        if (feat_rd_en) begin
            feat_q    <= feat_mem[feat_rd_addr];
            cat_vld_q <= cat_vld_reg[feat_rd_addr];
        end
    end

    // Category counts read as numeric until written
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cat_vld_reg <= '0;
        end else if (feat_we_cat) begin
            cat_vld_reg[feat_wr_addr] <= 1'b1;
        end
    end

    assign feat_idx_ok  = (in_index < INDEX_W'(FEATURES));
    assign feat_wr_addr = in_index[FEAT_AW-1:0];

    // Split evaluation on the fetched feature
    logic signed [VALUE_W-1:0] feat_x;
    logic [CAT_W-1:0]          ncat;
    logic [VALUE_W-17:0]       cat_c;
    logic                      cat_in_range;
    logic [4:0]                mask_bit;
    logic                      go_left;
    logic                      limit_hit;

    assign feat_x       = feat_q[VALUE_W-1:0];
    assign ncat         = cat_vld_q ? feat_q[CAT_W+VALUE_W-1:VALUE_W] : CAT_NUMERIC;
    assign cat_c        = {1'b0, feat_x[VALUE_W-2:16]};
    assign cat_in_range = !feat_x[VALUE_W-1] && (cat_c != '0)
                          && (cat_c <= (VALUE_W-16)'(ncat))
                          && (cat_c <= (VALUE_W-16)'(MAX_CATEGORIES))
                          && (cat_c <= (VALUE_W-16)'(MASK_W));
    assign mask_bit     = 5'(cat_c - (VALUE_W-16)'(1));

    always_comb begin
        if (ncat == CAT_NUMERIC) begin
            go_left = (feat_x <= node_q.value);
        end else begin
            go_left = cat_in_range && node_q.category_mask[mask_bit];
        end
    end

    assign limit_hit = ({1'b0, visits_reg} + (LIMIT_W+1)'(1)) >= {1'b0, limit_eff};

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && in_func == FUNC_PREDICT) begin
                    state_next = ST_NODE;
                end
            end
            ST_NODE: begin
                if (node_q.is_leaf || limit_hit) begin
                    if (!m_tvalid_reg || m_tready) begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    state_next = ST_FEAT;
                end
            end
            ST_FEAT: begin
                state_next = ST_NODE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath control
    always_comb begin
        s_tready     = 1'b0;
        node_we      = 1'b0;
        node_rd_en   = 1'b0;
        node_rd_addr = node_reg;
        feat_we_val  = 1'b0;
        feat_we_cat  = 1'b0;
        feat_rd_en   = 1'b0;
        feat_rd_addr = node_q.split_var;
        result_load  = 1'b0;
        node_next    = node_reg;
        visits_next  = visits_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_accept) begin
                    unique case (in_func)
                        FUNC_WR_NODE: begin
                            node_we = ({1'b0, in_index} < (INDEX_W+1)'(NODES));
                        end
                        FUNC_WR_FEAT: begin
                            feat_we_val = feat_idx_ok;
                        end
                        FUNC_WR_CAT: begin
                            feat_we_cat = feat_idx_ok;
                        end
                        FUNC_PREDICT: begin
                            node_rd_en   = 1'b1;
                            node_rd_addr = '0;
                            node_next    = '0;
                            visits_next  = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_NODE: begin
                if (node_q.is_leaf || limit_hit) begin
                    result_load = !m_tvalid_reg || m_tready;
                end else begin
                    feat_rd_en = 1'b1;
                end
            end
            ST_FEAT: begin
                // Take the branch and fetch the next node
                node_next    = go_left ? node_q.left_child : node_q.right_child;
                node_rd_en   = 1'b1;
                node_rd_addr = node_next;
                visits_next  = visits_reg + LIMIT_W'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            node_reg   <= '0;
            visits_reg <= '0;
        end else begin
            state_reg  <= state_next;
            node_reg   <= node_next;
            visits_reg <= visits_next;
        end
    end

    // Result register: hold until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (result_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (result_load) begin
            pred_reg     <= node_q.is_leaf ? node_q.value : '0;
            leaf_idx_reg <= node_reg;
            fault_reg    <= !node_q.is_leaf;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(M_TDATA_W-VALUE_W-INDEX_W-1)'(0), fault_reg,
                       INDEX_W'(leaf_idx_reg), pred_reg};

endmodule

@@ tb/decision_tree_inference_test.sv @@
// Self-checking testbench for the decision tree inference block.
module decision_tree_inference_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dti_pkg::*;

    // One input item in field form; packed into s_tdata/s_tuser on the way out.
    typedef struct packed {
        func_t            func;
        logic [7:0]       index;
        logic             is_leaf;
        logic [5:0]       split_var;
        logic [7:0]       left_child;
        logic [7:0]       right_child;
        logic [31:0]      value;
        logic [31:0]      category_mask;
        logic [5:0]       category_count;
    } tree_item_t;

    // One result item in field form.
    typedef struct packed {
        logic signed [31:0] prediction;
        logic [7:0]         leaf_index;
        logic               fault;
    } verdict_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    // Directed row: an item (or a step_limit write) with an optional hand-typed verdict.
    typedef struct packed {
        row_kind_t  kind;
        tree_item_t item;
        logic [8:0] limit;
        logic       typed;
        verdict_t   want;
    } script_row_t;

    localparam int CLK_HALF_NS    = 4;
    localparam int RESET_CYCLES   = 8;
    localparam int SETTLE_CYCLES  = 4;
    // Longest walk: 256 nodes, each a node read and a feature read, plus the output register.
    localparam int TAIL_CYCLES    = 600;
    localparam int RANDOM_ITEMS   = 1200;
    localparam int IDLE_PERCENT   = 19;
    localparam longint TIMEOUT_NS = 20_000_000;

    localparam verdict_t   NO_RESULT = '0;
    localparam verdict_t   LOOP_FAULT = '{32'h0, 8'd0, 1'b1};
    localparam tree_item_t NO_ITEM   = '0;
    localparam tree_item_t PREDICT   =
        '{FUNC_PREDICT, 8'd0, 1'b0, 6'd0, 8'd0, 8'd0, 32'h0, 32'h0, 6'd0};

    localparam int SCRIPT_LEN = 33;
    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        // root as a leaf, every link bit and mask bit set, largest value
        '{ROW_ITEM, '{FUNC_WR_NODE, 8'd0, 1'b1, 6'd63, 8'd255, 8'd255, 32'h7FFF_FFFF,
                      32'hFFFF_FFFF, 6'd0}, 9'd0, 1'b0, NO_RESULT},
        '{ROW_ITEM, PREDICT, 9'd0, 1'b1, '{32'h7FFF_FFFF, 8'd0, 1'b0}},
        // root as a leaf, smallest value
        '{ROW_ITEM, '{FUNC_WR_NODE, 8'd0, 1'b1, 6'd0, 8'd0, 8'd0, 32'h8000_0000,
                      32'h0, 6'd0}, 9'd0, 1'b0, NO_RESULT},
        '{ROW_ITEM, PREDICT, 9'd0, 1'b1, '{32'h8000_0000, 8'd0, 1'b0}},
        // two leaves under a numeric root on feature 0, threshold 0
        '{ROW_ITEM, '{FUNC_WR_NODE, 8'd1, 1'b1, 6'd0, 8'd0, 8'd0, 32'h0001_0000,
                      32'h0, 6'd0}, 9'd0, 1'b0, NO_RESULT},
        '{ROW_ITEM, '{FUNC_WR_NODE, 8'd2, 1'b1, 6'd0, 8'd0, 8'd0, 32'hFFFF_0000,
                      32'h0, 6'd0}, 9'd0, 1'b0, NO_RESULT},
        '{ROW_ITEM, '{FUNC_WR_NODE, 8'd0, 1'b0, 6'd0, 8'd1, 8'd2, 32'h0,
                      32'h0000_0002, 6'd0}, 9'd0, 1'b0, NO_RESULT},
        // feature equal to threshold goes left
        '{ROW_ITEM, '{FUNC_WR_FEAT, 8'd0, 1'b0, 6'd0, 8'd0, 8'd0, 32'h0,
                      32'h0, 6'd0}, 9'd0, 1'b0, NO_RESULT},
        '{ROW_ITEM, PREDICT, 9'd0, 1'b0, NO_RESULT},
        // feature 0 becomes categorical with three categories; category 2 is in the mask
        '{ROW_ITEM, '{FUNC_WR_CAT, 8'd0, 1'b0, 6'd0, 8'd0, 8'd0, 32'h0,
                      32'h0, 6'd3}, 9'd0, 1'b0, NO_RESULT},
        '{ROW_ITEM, '{FUNC_WR_FEAT, 8'd0, 1'b0, 6'd0, 8'd0, 8'd0, 32'h0002_0000,
                      32'h0, 6'd0}, 9'd0, 1'b0, NO_RESULT},
        '{ROW_ITEM, PREDICT, 9'd0, 1'b0, NO_RESULT},
        // category zero goes right
        '{ROW_ITEM, '{FUNC_WR_FEAT, 8'd0, 1'b0, 6'd0, 8'd0, 8'd0, 32'h0,
                      32'h0, 6'd0}, 9'd0, 1'b0, NO_RESULT},
        '{ROW_ITEM, PREDICT, 9'd0, 1'b0, NO_RESULT},
        // negative categorical value goes right
        '{ROW_ITEM, '{FUNC_WR_FEAT, 8'd0, 1'b0, 6'd0, 8'd0, 8'd0, 32'h8002_0000,
                      32'h0, 6'd0}, 9'd0, 1'b0, NO_RESULT},
        '{ROW_ITEM, PREDICT, 9'd0, 1'b0, NO_RESULT},
        // category above the count goes right
        '{ROW_ITEM, '{FUNC_WR_FEAT, 8'd0, 1'b0, 6'd0, 8'd0, 8'd0, 32'h0004_0000,
                      32'h0, 6'd0}, 9'd0, 1'b0, NO_RESULT},
        '{ROW_ITEM, PREDICT, 9'd0, 1'b0, NO_RESULT},
        // no categories at all: always right
        '{ROW_ITEM, '{FUNC_WR_CAT, 8'd0, 1'b0, 6'd0, 8'd0, 8'd0, 32'h0,
                      32'h0, 6'd0}, 9'd0, 1'b0, NO_RESULT},
        '{ROW_ITEM, PREDICT, 9'd0, 1'b0, NO_RESULT},
        // widest category count, top mask bit
        '{ROW_ITEM, '{FUNC_WR_CAT, 8'd0, 1'b0, 6'd0, 8'd0, 8'd0, 32'h0,
                      32'h0, 6'd32}, 9'd0, 1'b0, NO_RESULT},
        '{ROW_ITEM, '{FUNC_WR_NODE, 8'd0, 1'b0, 6'd0, 8'd1, 8'd2, 32'h0,
                      32'h8000_0000, 6'd0}, 9'd0, 1'b0, NO_RESULT},
        '{ROW_ITEM, '{FUNC_WR_FEAT, 8'd0, 1'b0, 6'd0, 8'd0, 8'd0, 32'h0020_0000,
                      32'h0, 6'd0}, 9'd0, 1'b0, NO_RESULT},
        '{ROW_ITEM, PREDICT, 9'd0, 1'b0, NO_RESULT},
        // feature writes beyond the feature table are dropped
        '{ROW_ITEM, '{FUNC_WR_FEAT, 8'd200, 1'b0, 6'd0, 8'd0, 8'd0, 32'h1234_5678,
                      32'h0, 6'd0}, 9'd0, 1'b0, NO_RESULT},
        '{ROW_ITEM, '{FUNC_WR_CAT, 8'd255, 1'b0, 6'd0, 8'd0, 8'd0, 32'h0,
                      32'h0, 6'd5}, 9'd0, 1'b0, NO_RESULT},
        // root pointing to itself: the step limit always runs out at node 0
        '{ROW_ITEM, '{FUNC_WR_NODE, 8'd0, 1'b0, 6'd0, 8'd0, 8'd0, 32'h0,
                      32'h0, 6'd0}, 9'd0, 1'b0, NO_RESULT},
        '{ROW_CFG, NO_ITEM, 9'd1, 1'b0, NO_RESULT},
        '{ROW_ITEM, PREDICT, 9'd0, 1'b1, LOOP_FAULT},
        // a zero limit acts as one
        '{ROW_CFG, NO_ITEM, 9'd0, 1'b0, NO_RESULT},
        '{ROW_ITEM, PREDICT, 9'd0, 1'b1, LOOP_FAULT},
        '{ROW_CFG, NO_ITEM, 9'd256, 1'b0, NO_RESULT},
        '{ROW_ITEM, PREDICT, 9'd0, 1'b1, LOOP_FAULT}
    };

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [LIMIT_W-1:0]   cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [1:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Shadow copy of the block's memories and register.
    node_entry_t        tree_nodes [NODES];
    bit                 node_seen [NODES];
    logic signed [31:0] sample_values [FEATURES];
    bit                 sample_seen [FEATURES];
    logic [5:0]         feature_kinds [FEATURES];
    logic [8:0]         walk_limit;

    verdict_t pending_results [$];
    verdict_t front;
    int       errors = 0;
    int       items_sent = 0;
    bit       quiet = 1'b0;

    decision_tree_inference DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #(CLK_HALF_NS) aclk = ~aclk;
    end

    // Numeric nodes compare signed; categorical nodes look up the mask bit of
    // the 1-based category held in the integer part of the feature.
    function automatic logic branch_left(input node_entry_t e);
        logic signed [31:0] x;
        logic [5:0]         cats;
        int                 c;
        x    = sample_values[e.split_var];
        cats = feature_kinds[e.split_var];
        if (cats == CAT_NUMERIC) return x <= $signed(e.value);
        if (x < 0) return 1'b0;
        c = int'(x[31:16]);
        if (c < 1 || c > int'(cats) || c > MAX_CATEGORIES) return 1'b0;
        return e.category_mask[c-1];
    endfunction

    // Walk from the root. Report the first unwritten node or feature touched
    // (hole_node / hole_feat, -1 when none) so that the caller can fill it first.
    function automatic verdict_t walk_tree(output int hole_node, output int hole_feat);
        verdict_t    v;
        node_entry_t e;
        int          node;
        int          visits;
        int          lim;
        v = '0;
        hole_node = -1;
        hole_feat = -1;
        lim = (walk_limit == 0) ? 1 : int'(walk_limit);
        node = 0;
        visits = 0;
        forever begin
            if (!node_seen[node]) begin
                hole_node = node;
                return v;
            end
            e = tree_nodes[node];
            if (e.is_leaf) begin
                v.prediction = $signed(e.value);
                v.leaf_index = 8'(node);
                v.fault      = 1'b0;
                return v;
            end
            if (!sample_seen[e.split_var]) begin
                hole_feat = int'(e.split_var);
                return v;
            end
            if (visits + 1 >= lim) break;
            node = branch_left(e) ? int'(e.left_child) : int'(e.right_child);
            visits++;
        end
        v.prediction = '0;
        v.leaf_index = 8'(node);
        v.fault      = 1'b1;
        return v;
    endfunction

    // Update the shadow state for an accepted item; queue the verdict of a predict.
    function automatic void apply_item(input tree_item_t it, input bit typed,
                                       input verdict_t given);
        int hn;
        int hf;
        case (it.func)
            FUNC_WR_NODE: begin
                tree_nodes[it.index] = '{it.is_leaf, it.split_var, it.left_child,
                                         it.right_child, it.value, it.category_mask};
                node_seen[it.index] = 1'b1;
            end
            FUNC_WR_FEAT: begin
                if (int'(it.index) < FEATURES) begin
                    sample_values[it.index] = it.value;
                    sample_seen[it.index] = 1'b1;
                end
            end
            FUNC_WR_CAT: begin
                if (int'(it.index) < FEATURES) feature_kinds[it.index] = it.category_count;
            end
            default: begin
                if (typed) pending_results.push_back(given);
                else pending_results.push_back(walk_tree(hn, hf));
            end
        endcase
    endfunction

    // Present one item, with random idle cycles ahead of it, and hold it until taken.
    task automatic send_item(input tree_item_t it, input bit typed = 1'b0,
                             input verdict_t given = '0);
        while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.func;
        s_tdata  <= {3'b000, it.category_count, it.category_mask, it.value,
                     it.right_child, it.left_child, it.split_var, it.is_leaf, it.index};
        do @(posedge aclk); while (!s_tready);
        apply_item(it, typed, given);
        items_sent++;
        quiet = (items_sent >= 400 && items_sent < 600);
    endtask

    // Write step_limit only once the block has drained and settled.
    task automatic set_limit(input logic [8:0] lim);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= lim;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        walk_limit = lim;
    endtask

    function automatic tree_item_t random_item(input func_t f);
        tree_item_t it;
        it.func           = f;
        it.index          = 8'($urandom);
        it.is_leaf        = 1'($urandom);
        it.split_var      = 6'($urandom);
        it.left_child     = 8'($urandom);
        it.right_child    = 8'($urandom);
        it.value          = $urandom;
        it.category_mask  = $urandom;
        it.category_count = 6'($urandom_range(0, 32));
        return it;
    endfunction

    // Feature value fitted to the feature's kind: mostly valid categories for
    // categorical features, with out-of-range and negative ones mixed in.
    function automatic tree_item_t sample_write(input int f);
        tree_item_t it;
        it = random_item(FUNC_WR_FEAT);
        it.index = 8'(f);
        if (feature_kinds[f] != CAT_NUMERIC && $urandom_range(0, 9) != 0)
            it.value[31:16] = 16'($urandom_range(0, 33));
        return it;
    endfunction

    // Fill every unwritten entry the walk would touch, then predict.
    task automatic predict_clean();
        int         hn;
        int         hf;
        verdict_t   v;
        tree_item_t it;
        forever begin
            v = walk_tree(hn, hf);
            if (hn < 0 && hf < 0) break;
            if (hn >= 0) begin
                it = random_item(FUNC_WR_NODE);
                it.index = 8'(hn);
            end else begin
                it = random_item(FUNC_WR_FEAT);
                it.index = 8'(hf);
            end
            send_item(it);
        end
        send_item(PREDICT);
    endtask

    // Result side: check each taken result against the oldest expectation and
    // stall at random outside the quiet stretch.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: prediction %0d leaf %0d fault %0d",
                       $signed(m_tdata[31:0]), m_tdata[39:32], m_tdata[40]);
                errors++;
            end else begin
                front = pending_results.pop_front();
                if (m_tdata[31:0] !== front.prediction) begin
                    $error("prediction: expected %0d, got %0d",
                           front.prediction, $signed(m_tdata[31:0]));
                    errors++;
                end
                if (m_tdata[39:32] !== front.leaf_index) begin
                    $error("leaf_index: expected %0d, got %0d",
                           front.leaf_index, m_tdata[39:32]);
                    errors++;
                end
                if (m_tdata[40] !== front.fault) begin
                    $error("fault: expected %0d, got %0d", front.fault, m_tdata[40]);
                    errors++;
                end
            end
        end
        m_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    initial begin
        int         phase;
        int         n;
        int         base;
        int         k;
        int         random_stop;
        bit         broken;
        logic [8:0] lim;
        int         pool [6];
        tree_item_t it;

        // Shadow state after reset: nothing written, every feature numeric.
        for (int i = 0; i < NODES; i++) node_seen[i] = 1'b0;
        for (int i = 0; i < FEATURES; i++) begin
            sample_seen[i]   = 1'b0;
            feature_kinds[i] = CAT_NUMERIC;
        end
        walk_limit = STEP_LIMIT_RESET;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table: typed rows carry their verdict, the rest use the predictor.
        for (int r = 0; r < SCRIPT_LEN; r++) begin
            if (SCRIPT[r].kind == ROW_CFG) set_limit(SCRIPT[r].limit);
            else send_item(SCRIPT[r].item, SCRIPT[r].typed, SCRIPT[r].want);
        end

        // Random part: one small tree per phase, walked many times with fresh samples.
        random_stop = items_sent + RANDOM_ITEMS;
        phase = 0;
        while (items_sent < random_stop) begin
            case (phase % 4)
                0:       lim = 9'd1;
                1:       lim = 9'd256;
                2:       lim = 9'($urandom_range(2, 12));
                default: lim = 9'($urandom_range(1, 256));
            endcase
            set_limit(lim);

            // Pick the features this tree tests and set their kinds.
            foreach (pool[p]) begin
                pool[p] = $urandom_range(0, FEATURES - 1);
                it = random_item(FUNC_WR_CAT);
                it.index = 8'(pool[p]);
                if ($urandom_range(0, 1) == 0) it.category_count = CAT_NUMERIC;
                send_item(it);
                send_item(sample_write(pool[p]));
            end

            // Build the tree: children always further down, so walks end at a
            // leaf, except in the odd broken tree whose links go anywhere.
            n = $urandom_range(1, 24);
            base = $urandom_range(0, 256 - n);
            broken = ($urandom_range(0, 7) == 0);
            for (k = n - 1; k >= 0; k--) begin
                it = random_item(FUNC_WR_NODE);
                it.index = (k == 0) ? 8'd0 : 8'(base + k);
                it.is_leaf = (k == n - 1) || ($urandom_range(0, 3) == 0);
                it.split_var = 6'(pool[$urandom_range(0, 5)]);
                if (!it.is_leaf && !broken) begin
                    it.left_child  = 8'(base + $urandom_range(k + 1, n - 1));
                    it.right_child = 8'(base + $urandom_range(k + 1, n - 1));
                end
                send_item(it);
            end

            repeat ($urandom_range(4, 12)) begin
                repeat ($urandom_range(1, 3)) send_item(sample_write(pool[$urandom_range(0, 5)]));
                // Drop in a stray write now and then.
                if ($urandom_range(0, 9) == 0)
                    send_item(random_item(func_t'($urandom_range(0, 2))));
                predict_clean();
            end
            phase++;
        end

        // Drain, then give a late or extra result time to show.
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("decision_tree_inference_test: done, clean");
        end else begin
            $display("decision_tree_inference_test: done, errors");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #(TIMEOUT_NS);
        $display("decision_tree_inference_test: done, errors");
        $finish;
    end

endmodule
